FILE: sv/nshf_pkg.sv
package nshf_pkg;

  // Operation codes carried in the low bits of the input tdata.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Sequencer states of the query walk.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_e;

  // Width of the op field and of the fraction field in the packed result item.
  localparam int unsigned OP_BITS       = 2;
  localparam int unsigned OUT_FRAC_BITS = 16;

endpackage

FILE: sv/nshf_mul.sv
module nshf_mul #(
  parameter int unsigned W = 17
) (
  input  logic                clk_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic signed [2*W-1:0] p_o
);

  // Registered signed product; the sequencer collects it in the following cycle.
  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

FILE: sv/nshf_div.sv
module nshf_div #(
  parameter int unsigned NW = 35,
  parameter int unsigned FB = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [NW-1:0] den_i,
  output logic          done_o,
  output logic [FB-1:0] quot_o
);

  import nshf_pkg::*;

  localparam int unsigned CNT_W = $clog2(FB + 1);

  logic [NW:0]      rem_q, rem_d;
  logic [NW-1:0]    den_q;
  logic [FB-1:0]    quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NW:0]      shifted;

  // One restoring step per cycle: shift, compare, subtract.
  always_comb begin
    shifted = {rem_q[NW-1:0], 1'b0};
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quot_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d  = shifted - {1'b0, den_q};
        quot_d = {quot_q[FB-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[FB-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(FB - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: sv/nearest_segment_hit_finder_core.sv
// Clear and append transactions are taken in idle and leave the block ready for the next one.
// A query holds the input until the sequencer returns to idle: it walks every stored segment,
// waits on the divider for each counted crossing, and then waits in the done state until the
// output register is free. Each segment costs fetch, load, the multiplier steps (six products
// through the registered shared multiplier) and the check.
// Reset clears the segment count, the sequencer and the output valid; the segment
// memory itself is not cleared and only entries below the count are ever used.
module nearest_segment_hit_finder_core #(
  parameter int unsigned MAX_SEGMENTS  = 1024,
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 16,
  localparam int unsigned IN_BITS      = 2 + 4 * COORD_BITS,
  localparam int unsigned IN_W         = ((IN_BITS + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // tdata: op[1:0], x_start, y_start, x_end, y_end (COORD_BITS each), zero pad
  input  logic [IN_W-1:0] s_axis_tdata_i,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // tdata: hit[0], hit_fraction[16:1], zero pad
  output logic [23:0]     m_axis_tdata_o,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i
);

  import nshf_pkg::*;

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned MW    = C + 1;
  localparam int unsigned PW    = 2 * MW;
  localparam int unsigned AW    = PW + 1;
  localparam int unsigned CW    = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned ADW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned SEG_W = 4 * C;
  localparam int unsigned FB    = FRACTION_BITS;

  // Input field unpacking.
  op_e          in_op;
  logic [C-1:0] in_xs, in_ys, in_xe, in_ye;
  assign in_op = op_e'(s_axis_tdata_i[OP_BITS-1:0]);
  assign in_xs = s_axis_tdata_i[OP_BITS+C-1:OP_BITS];
  assign in_ys = s_axis_tdata_i[OP_BITS+2*C-1:OP_BITS+C];
  assign in_xe = s_axis_tdata_i[OP_BITS+3*C-1:OP_BITS+2*C];
  assign in_ye = s_axis_tdata_i[OP_BITS+4*C-1:OP_BITS+3*C];

  logic in_fire, out_fire;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [2:0]    k_q, k_d;
  logic          found_q, found_d;
  logic [FB-1:0] best_q, best_d;
  logic          out_v_q, out_v_d;
  logic          out_hit_q;
  logic [OUT_FRAC_BITS-1:0] out_frac_q;
  logic          load_out;

  // Query operands.
  logic signed [C-1:0]  px_q, py_q;
  logic signed [MW-1:0] dx_q, dy_q, ex_q, ey_q, wx_q, wy_q;
  logic signed [AW-1:0] den_q, tn_q, un_q;

  // Segment memory, one write and one registered read port.
  logic [SEG_W-1:0] mem [MAX_SEGMENTS];
  logic [SEG_W-1:0] rdata_q;
  logic             mem_we;
  assign mem_we = in_fire && (in_op == OP_APPEND) && (count_q < CW'(MAX_SEGMENTS));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[ADW-1:0]] <= {in_ye, in_xe, in_ys, in_xs};
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[idx_q[ADW-1:0]];
  end

  // Shared multiplier with operand selection by step.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  always_comb begin
    unique case (k_q)
      3'd0:    begin mul_a = dx_q; mul_b = ey_q; end
      3'd1:    begin mul_a = dy_q; mul_b = ex_q; end
      3'd2:    begin mul_a = wx_q; mul_b = ey_q; end
      3'd3:    begin mul_a = wy_q; mul_b = ex_q; end
      3'd4:    begin mul_a = wx_q; mul_b = dy_q; end
      default: begin mul_a = wy_q; mul_b = dx_q; end
    endcase
  end

  nshf_mul #(.W(MW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Sign normalization and the crossing test: strictly inside the query segment, ends included on the stored one.
  logic signed [AW-1:0] den_n, tn_n, un_n;
  logic                 pass;
  always_comb begin
    if (den_q[AW-1]) begin
      den_n = -den_q;
      tn_n  = -tn_q;
      un_n  = -un_q;
    end else begin
      den_n = den_q;
      tn_n  = tn_q;
      un_n  = un_q;
    end
    pass = (den_q != '0) && (tn_n > 0) && (tn_n < den_n) && (un_n >= 0) && (un_n <= den_n);
  end

  logic          div_start, div_done;
  logic [FB-1:0] div_quot;
  assign div_start = (state_q == ST_CHECK) && pass;

  nshf_div #(.NW(AW), .FB(FB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (tn_n),
    .den_i   (den_n),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  logic last_seg;
  assign last_seg = (idx_q + 1'b1) == count_q;

  // Sequencer: next state and control.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    k_d      = k_q;
    found_d  = found_q;
    best_d   = best_q;
    load_out = 1'b0;
    out_v_d  = out_v_q && !out_fire;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          priority case (in_op)
            OP_CLEAR:  count_d = '0;
            OP_APPEND: if (mem_we) count_d = count_q + 1'b1;
            OP_QUERY: begin
              idx_d   = '0;
              found_d = 1'b0;
              best_d  = '0;
              state_d = (count_q == '0) ? ST_DONE : ST_FETCH;
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: state_d = ST_LOAD;
      ST_LOAD: begin
        k_d     = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        k_d = k_q + 1'b1;
        if (k_q == 3'd6) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (pass) begin
          state_d = ST_DIV;
        end else if (last_seg) begin
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_FETCH;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (!found_q || div_quot < best_q) begin
            best_d = div_quot;
          end
          found_d = 1'b1;
          if (last_seg) begin
            state_d = ST_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        if (!out_v_q || m_axis_tready_i) begin
          load_out = 1'b1;
          out_v_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload and datapath registers.
  logic [FB+OUT_FRAC_BITS-1:0] best_ext;
  assign best_ext = {{OUT_FRAC_BITS{1'b0}}, best_q};

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    k_q     <= k_d;
    found_q <= found_d;
    best_q  <= best_d;
    if (in_fire && in_op == OP_QUERY) begin
      px_q <= in_xs;
      py_q <= in_ys;
      dx_q <= MW'($signed(in_xe)) - MW'($signed(in_xs));
      dy_q <= MW'($signed(in_ye)) - MW'($signed(in_ys));
    end
    if (state_q == ST_LOAD) begin
      ex_q <= MW'($signed(rdata_q[3*C-1:2*C])) - MW'($signed(rdata_q[C-1:0]));
      ey_q <= MW'($signed(rdata_q[4*C-1:3*C])) - MW'($signed(rdata_q[2*C-1:C]));
      wx_q <= MW'($signed(rdata_q[C-1:0])) - MW'(px_q);
      wy_q <= MW'($signed(rdata_q[2*C-1:C])) - MW'(py_q);
    end
    if (state_q == ST_MUL) begin
      unique case (k_q)
        3'd1:    den_q <= AW'(prod);
        3'd2:    den_q <= den_q - AW'(prod);
        3'd3:    tn_q  <= AW'(prod);
        3'd4:    tn_q  <= tn_q - AW'(prod);
        3'd5:    un_q  <= AW'(prod);
        3'd6:    un_q  <= un_q - AW'(prod);
        default: ;
      endcase
    end
    if (load_out) begin
      out_hit_q  <= found_q;
      out_frac_q <= found_q ? best_ext[OUT_FRAC_BITS-1:0] : '0;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {7'b0, out_frac_q, out_hit_q};

  // Checks on the sequencer and the result path.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_SEGMENTS))
    else $error("segment count beyond capacity");

  a_no_miss_fraction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !out_hit_q) |-> (out_frac_q == '0))
    else $error("fraction set without a hit");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH) |-> (idx_q < count_q))
    else $error("segment walk past stored count");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside its wait state");

endmodule

FILE: tb/sv/nshf_checker.sv
module nshf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [71:0] in_tdata_i,
  input  logic        in_tvalid_i,
  input  logic        in_tready_i,
  input  logic [23:0] out_tdata_i,
  input  logic        out_tvalid_i,
  input  logic        out_tready_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          hits_seen_o,
  output int          queries_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import nshf_pkg::*;

  typedef struct packed {
    logic signed [15:0] ax, ay, bx, by;
  } seg_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] frac;
  } answer_t;

  seg_t    seg_mem [1024];
  int      seg_cnt;
  answer_t answer_q [$];

  // Exact crossing search over every stored segment.
  function automatic answer_t nearest_crossing(logic signed [15:0] px, logic signed [15:0] py,
                                               logic signed [15:0] qx, logic signed [15:0] qy);
    answer_t a;
    longint dx, dy, ex, ey, wx, wy, den, tn, un;
    logic [63:0] q, r;
    a = '0;
    dx = longint'(qx) - px;
    dy = longint'(qy) - py;
    for (int i = 0; i < seg_cnt; i++) begin
      ex = longint'(seg_mem[i].bx) - seg_mem[i].ax;
      ey = longint'(seg_mem[i].by) - seg_mem[i].ay;
      wx = longint'(seg_mem[i].ax) - px;
      wy = longint'(seg_mem[i].ay) - py;
      den = dx * ey - dy * ex;
      tn = wx * ey - wy * ex;
      un = wx * dy - wy * dx;
      if (den == 0) continue;
      if (den < 0) begin
        den = -den;
        tn = -tn;
        un = -un;
      end
      if (!(tn > 0 && tn < den && un >= 0 && un <= den)) continue;
      q = 0;
      r = tn;
      for (int b = 0; b < 16; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q[0] = 1'b1;
        end
      end
      if (!a.hit || q[15:0] < a.frac) a.frac = q[15:0];
      a.hit = 1'b1;
    end
    return a;
  endfunction

  // Track input transactions and compare result transactions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    op_e op;
    if (!rst_ni) begin
      seg_cnt <= 0;
      fail_count_o <= 0;
      hits_seen_o <= 0;
      queries_seen_o <= 0;
    end else begin
      if (in_tvalid_i && in_tready_i) begin
        op = op_e'(in_tdata_i[1:0]);
        case (op)
          OP_CLEAR: seg_cnt <= 0;
          OP_APPEND: begin
            if (seg_cnt < 1024) begin
              seg_mem[seg_cnt] <= {in_tdata_i[17:2], in_tdata_i[33:18],
                                   in_tdata_i[49:34], in_tdata_i[65:50]};
              seg_cnt <= seg_cnt + 1;
            end
          end
          OP_QUERY: answer_q.insert(answer_q.size(),
                                    nearest_crossing(in_tdata_i[17:2], in_tdata_i[33:18],
                                                     in_tdata_i[49:34], in_tdata_i[65:50]));
          default: ;
        endcase
      end
      if (out_tvalid_i && out_tready_i) begin
        // The hit flag sits in bit 0, the fraction just above it.
        got = {out_tdata_i[0], out_tdata_i[16:1]};
        queries_seen_o <= queries_seen_o + 1;
        if (got.hit) hits_seen_o <= hits_seen_o + 1;
        if (answer_q.size() == 0) begin
          $error("unexpected result transaction %h", out_tdata_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = answer_q.pop_front();
          if (got.hit !== want.hit || got.frac !== want.frac || out_tdata_i[23:17] !== '0) begin
            if (got.hit !== want.hit) $error("hit expected %0d actual %0d", want.hit, got.hit);
            if (got.frac !== want.frac)
              $error("hit_fraction expected %0d actual %0d", want.frac, got.frac);
            if (out_tdata_i[23:17] !== '0) $error("pad expected 0 actual %h", out_tdata_i[23:17]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = answer_q.size();
endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nshf_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic [71:0] s_tdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready;
  int          fail_count, pending, hits_seen, queries_seen;
  int          cycle_cnt;
  bit          calm_phase;
  bit          rand_phase;
  bit          hold_off;
  int          store_cnt;

  nearest_segment_hit_finder_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tdata_i(s_tdata), .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready)
  );

  nshf_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_tdata_i(s_tdata), .in_tvalid_i(s_tvalid), .in_tready_i(s_tready),
    .out_tdata_i(m_tdata), .out_tvalid_i(m_tvalid), .out_tready_i(m_tready),
    .fail_count_o(fail_count), .pending_o(pending),
    .hits_seen_o(hits_seen), .queries_seen_o(queries_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off.
  always @(posedge clk_i) begin
    if (hold_off) m_tready <= 1'b0;
    else if (calm_phase) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(99) >= 24);
  end

  // The long hold-off lands among the short random queries so the input stalls.
  initial begin
    wait (rand_phase);
    repeat (300) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (4000) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Drive one input transaction with random leading idle cycles.
  task automatic send(op_e op, logic [15:0] xs, logic [15:0] ys, logic [15:0] xe,
                      logic [15:0] ye);
    while (!calm_phase && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, ye, xe, ys, xs, op};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    if (op == OP_CLEAR) store_cnt = 0;
    if (op == OP_APPEND && store_cnt < 1024) store_cnt++;
  endtask

  function automatic logic [15:0] coord(int span);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(2 * span)) - span);
  endfunction

  initial begin
    int kind;
    calm_phase = 1'b0;
    rand_phase = 1'b0;
    hold_off = 1'b0;
    cycle_cnt = 0;
    store_cnt = 0;
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty store, extremes, endpoints, parallel, degenerate, op 3.
    send(OP_QUERY, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send(OP_APPEND, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send(OP_QUERY, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
    send(OP_APPEND, 16'd0, 16'd0, 16'd10, 16'd0);
    send(OP_QUERY, 16'd0, 16'hfffb, 16'd0, 16'd5);
    send(OP_QUERY, 16'd5, 16'd0, 16'd5, 16'd5);
    send(OP_QUERY, 16'd5, 16'hfffb, 16'd5, 16'd0);
    send(OP_QUERY, 16'd0, 16'd1, 16'd10, 16'd1);
    send(OP_QUERY, 16'd0, 16'd0, 16'd20, 16'd0);
    send(OP_QUERY, 16'd3, 16'd3, 16'd3, 16'd3);
    send(OP_QUERY, 16'd4, 16'hffff, 16'd4, 16'h7fff);
    send(OP_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send(OP_QUERY, 16'd0, 16'hfffb, 16'd0, 16'd5);
    send(OP_APPEND, 16'd3, 16'd3, 16'd3, 16'd3);
    send(OP_QUERY, 16'd0, 16'd0, 16'd6, 16'd6);

    // Fill the store to capacity once, then check appends beyond it are ignored.
    send(OP_CLEAR, 0, 0, 0, 0);
    while (store_cnt < 1024)
      send(OP_APPEND, coord(30000), coord(30000), coord(30000), coord(30000));
    send(OP_APPEND, 16'h8000, 16'h0, 16'h7fff, 16'h0);
    send(OP_QUERY, 16'h0, 16'h8000, 16'h0, 16'h7fff);
    send(OP_QUERY, coord(30000), coord(30000), coord(30000), coord(30000));
    send(OP_CLEAR, 0, 0, 0, 0);

    // Random: mostly small stores built then queried.
    rand_phase = 1'b1;
    for (int n = 0; n < 540; n++) begin
      calm_phase = (n >= 200 && n < 280);
      kind = $urandom_range(99);
      if (kind < 4) send(OP_CLEAR, coord(100), coord(100), coord(100), coord(100));
      else if (kind < 6) send(OP_NONE, coord(100), coord(100), coord(100), coord(100));
      else if (kind < 50 && store_cnt < 24)
        send(OP_APPEND, coord(200), coord(200), coord(200), coord(200));
      else if (kind < 50) send(OP_CLEAR, 0, 0, 0, 0);
      else send(OP_QUERY, coord(200), coord(200), coord(200), coord(200));
    end
    s_tvalid <= 1'b0;
    calm_phase = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20000) @(posedge clk_i);
    $display("Ran %0d queries, %0d of them hits, with clears, full-store and no-op items.",
             queries_seen, hits_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
